/* design/stt_pkg.sv */
// shared constants, token types and character class helpers of the tokenizer
package stt_pkg;

  // position counter width; token_start reports its low 16 bits
  localparam int unsigned POS_BITS = 16;
  localparam int unsigned KIND_W = 5;
  localparam int unsigned OFS_W = 16;
  localparam int unsigned WIN_W = 48;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_IDX_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_EOF       = 5'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT     = 5'd1;
  localparam logic [KIND_W-1:0] KIND_INT       = 5'd2;
  localparam logic [KIND_W-1:0] KIND_FLOAT     = 5'd3;
  localparam logic [KIND_W-1:0] KIND_KW_FN     = 5'd4;
  localparam logic [KIND_W-1:0] KIND_KW_INT    = 5'd5;
  localparam logic [KIND_W-1:0] KIND_KW_FLOAT  = 5'd6;
  localparam logic [KIND_W-1:0] KIND_KW_RETURN = 5'd7;
  localparam logic [KIND_W-1:0] KIND_PLUS      = 5'd8;
  localparam logic [KIND_W-1:0] KIND_MINUS     = 5'd9;
  localparam logic [KIND_W-1:0] KIND_STAR      = 5'd10;
  localparam logic [KIND_W-1:0] KIND_SLASH     = 5'd11;
  localparam logic [KIND_W-1:0] KIND_ASSIGN    = 5'd12;
  localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd13;
  localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd14;
  localparam logic [KIND_W-1:0] KIND_LBRACE    = 5'd15;
  localparam logic [KIND_W-1:0] KIND_RBRACE    = 5'd16;
  localparam logic [KIND_W-1:0] KIND_COLON     = 5'd17;
  localparam logic [KIND_W-1:0] KIND_SEMI      = 5'd18;
  localparam logic [KIND_W-1:0] KIND_COMMA     = 5'd19;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 5'd20;

  // keyword patterns, last character in the low byte
  localparam logic [WIN_W-1:0] KW_FN     = 48'h0000_0000_666E;
  localparam logic [WIN_W-1:0] KW_INT    = 48'h0000_0069_6E74;
  localparam logic [WIN_W-1:0] KW_FLOAT  = 48'h0066_6C6F_6174;
  localparam logic [WIN_W-1:0] KW_RETURN = 48'h7265_7475_726E;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFS_W-1:0]  start;
    logic [OFS_W-1:0]  length;
    logic              last;
  } tok_t;

  // what one scanned byte produces
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } step_res_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // zero means not a punctuation character
  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
    logic [KIND_W-1:0] k;
    case (b)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h3D:   k = KIND_ASSIGN;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h3A:   k = KIND_COLON;
      8'h3B:   k = KIND_SEMI;
      8'h2C:   k = KIND_COMMA;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] ident_kind(input logic [WIN_W-1:0] w);
    logic [KIND_W-1:0] k;
    if (w == KW_FN) k = KIND_KW_FN;
    else if (w == KW_INT) k = KIND_KW_INT;
    else if (w == KW_FLOAT) k = KIND_KW_FLOAT;
    else if (w == KW_RETURN) k = KIND_KW_RETURN;
    else k = KIND_IDENT;
    return k;
  endfunction

endpackage

/* design/source_text_tokenizer_unit.sv */
// top level of the byte-serial source text tokenizer
//
// usage:
//   source text enters one byte per item on the s_axis channel; byte zero
//   ends the text, flushes any open token, emits an eof token and returns
//   the scanner to its reset state (position zero)
//   tokens leave on the m_axis channel: kind, start offset and length in
//   tdata, tlast set on the final token caused by one input byte
//   a byte inside an identifier or number, or whitespace that closes no token, gives no token
// timing:
//   a byte is captured in the input register, scanned once the queue has
//   room and its tokens are written to a four-entry token queue, from
//   whose registered head the first token is offered on m_axis
//   one byte per cycle is taken as long as the queue has room for two
//   tokens; the queue hands out one token per output transfer
// reset and stall:
//   rst_ni clears the scanner and empties the queue
//   when m_axis_tready_i is low the queue fills and s_axis_tready_o drops
//   once fewer than two free entries remain; nothing is dropped
module source_text_tokenizer_unit import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  // token channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [4:0] token_kind, [20:5] token_offset,
                                        // [36:21] token_length, [39:37] zero
  output logic        m_axis_tlast_o    // last_of_run
);

  logic [7:0] byte_q;
  logic       byte_vld_q;
  logic       room;
  logic       step;
  step_res_t  res;
  tok_t       tok;

  // the held byte is scanned once the queue can take both possible tokens
  assign step            = byte_vld_q && room;
  assign s_axis_tready_o = !byte_vld_q || step;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      byte_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      byte_vld_q <= s_axis_tvalid_i;
    end
  end

  stt_scan_core u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step),
    .text_byte_i (byte_q),
    .res_o       (res)
  );

  stt_tok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .res_i   (res),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .tok_o   (tok)
  );

  assign m_axis_tdata_o = {3'b000, tok.length, tok.start, tok.kind};
  assign m_axis_tlast_o = tok.last;

endmodule

/* design/stt_scan_core.sv */
// scanner state and the one-byte next-state and token logic
module stt_scan_core import stt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  logic [7:0] text_byte_i,
  output step_res_t  res_o
);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_IDENT = 2'd1;
  localparam logic [1:0] MODE_INT   = 2'd2;
  localparam logic [1:0] MODE_FLOAT = 2'd3;

  logic [1:0]          mode_q, mode_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] origin_q, origin_d;
  logic [WIN_W-1:0]    win_q, win_d;
  logic                halted_q, halted_d;

  logic [POS_BITS-1:0] pos_inc;
  logic [POS_BITS-1:0] diff;
  logic [32:0]         diff_ext;
  logic [32:0]         pos_ext;
  logic [32:0]         origin_ext;
  logic [OFS_W-1:0]    pend_len;
  logic [KIND_W-1:0]   pend_kind;
  logic [KIND_W-1:0]   pk;
  logic                pend_vld, new_vld, cont;
  tok_t                pend_tok, new_tok;

  assign pos_inc    = (pos_q == {POS_BITS{1'b1}}) ? pos_q : pos_q + 1'b1;
  assign diff       = pos_q - origin_q;
  assign diff_ext   = 33'(diff);
  assign pos_ext    = 33'(pos_q);
  assign origin_ext = 33'(origin_q);
  assign pend_len   = (diff_ext > 33'd65535) ? 16'hFFFF : diff_ext[15:0];
  assign pk         = punct_kind(text_byte_i);

  always_comb begin
    case (mode_q)
      MODE_IDENT: pend_kind = ident_kind(win_q);
      MODE_INT:   pend_kind = KIND_INT;
      MODE_FLOAT: pend_kind = KIND_FLOAT;
      default:    pend_kind = KIND_EOF;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    origin_d = origin_q;
    win_d    = win_q;
    halted_d = halted_q;
    pend_vld = 1'b0;
    new_vld  = 1'b0;
    cont     = 1'b0;
    pend_tok = '{kind: pend_kind, start: origin_ext[15:0], length: pend_len, last: 1'b0};
    new_tok  = '{kind: KIND_EOF, start: pos_ext[15:0], length: 16'd0, last: 1'b0};

    if (text_byte_i == 8'h00) begin
      // end of text: pending token, then eof, then back to reset state
      pend_vld = !halted_q && (mode_q != MODE_START);
      new_vld  = 1'b1;
      mode_d   = MODE_START;
      pos_d    = '0;
      origin_d = '0;
      win_d    = '0;
      halted_d = 1'b0;
    end else if (!halted_q) begin
      case (mode_q)
        MODE_IDENT: begin
          if (is_alpha(text_byte_i) || is_digit(text_byte_i)) begin
            cont  = 1'b1;
            pos_d = pos_inc;
            if (win_q[47:40] != 8'h00) win_d = '1;
            else win_d = {win_q[39:0], text_byte_i};
          end
        end
        MODE_INT: begin
          if (is_digit(text_byte_i)) begin
            cont  = 1'b1;
            pos_d = pos_inc;
          end else if (text_byte_i == 8'h2E) begin
            cont   = 1'b1;
            mode_d = MODE_FLOAT;
            pos_d  = pos_inc;
          end
        end
        MODE_FLOAT: begin
          if (is_digit(text_byte_i)) begin
            cont  = 1'b1;
            pos_d = pos_inc;
          end
        end
        default: ;
      endcase

      if (!cont) begin
        // terminating byte: close any pending token, rescan from start
        pend_vld = (mode_q != MODE_START);
        mode_d   = MODE_START;
        win_d    = '0;
        if (is_space(text_byte_i)) begin
          pos_d = pos_inc;
        end else if (is_alpha(text_byte_i)) begin
          mode_d   = MODE_IDENT;
          origin_d = pos_q;
          win_d    = {40'd0, text_byte_i};
          pos_d    = pos_inc;
        end else if (is_digit(text_byte_i)) begin
          mode_d   = MODE_INT;
          origin_d = pos_q;
          pos_d    = pos_inc;
        end else if (pk != KIND_EOF) begin
          new_vld        = 1'b1;
          new_tok.kind   = pk;
          new_tok.length = 16'd1;
          pos_d          = pos_inc;
        end else begin
          new_vld        = 1'b1;
          new_tok.kind   = KIND_ERROR;
          new_tok.length = 16'd1;
          halted_d       = 1'b1;
        end
      end
    end

    // the final token of the byte carries the last flag
    new_tok.last = 1'b1;
    res_o.tok1   = new_tok;
    if (pend_vld && new_vld) begin
      res_o.count = 2'd2;
      res_o.tok0  = pend_tok;
    end else if (pend_vld) begin
      res_o.count     = 2'd1;
      res_o.tok0      = pend_tok;
      res_o.tok0.last = 1'b1;
    end else if (new_vld) begin
      res_o.count = 2'd1;
      res_o.tok0  = new_tok;
    end else begin
      res_o.count = 2'd0;
      res_o.tok0  = new_tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_START;
      pos_q    <= '0;
      origin_q <= '0;
      win_q    <= '0;
      halted_q <= 1'b0;
    end else if (step_en_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      origin_q <= origin_d;
      win_q    <= win_d;
      halted_q <= halted_d;
    end
  end

endmodule

/* design/stt_tok_queue.sv */
// small token queue, takes up to two tokens a cycle and hands out one when the reader is ready
module stt_tok_queue import stt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  step_res_t res_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output tok_t      tok_o
);

  tok_t               mem_q [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_q, wr_d;
  logic [Q_IDX_W-1:0] rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic [Q_IDX_W-1:0] wr_next;
  logic [1:0]         n_push;
  logic               pop;

  assign room_o  = cnt_q <= Q_CNT_W'(Q_DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign tok_o   = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign n_push  = push_i ? res_i.count : 2'd0;
  assign wr_next = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + Q_IDX_W'(n_push);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + Q_CNT_W'(n_push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= res_i.tok0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_next] <= res_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
